// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the bit-serial sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that implies a consequence in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/absb_pkg.sv =====
// Package with the types, codes and helper functions of the bit-serial sender.
package absb_pkg;

  localparam int ID_BITS    = 32;
  localparam int TIMER_BITS = 16;
  localparam int BL_W       = $clog2(ID_BITS + 1);
  localparam int IDX_W      = $clog2(ID_BITS);

  localparam logic [BL_W-1:0] BYTE_BITS = BL_W'(8);

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_BYTE  = 2'd2,
    CMD_ACK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_BIT      = 3'd0,
    EV_ID_ACK   = 3'd1,
    EV_BYTE_OK  = 3'd2,
    EV_ID_TO    = 3'd3,
    EV_BYTE_TO  = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    CFG_ID_VALUE = 2'd0,
    CFG_BIT_GAP  = 2'd1,
    CFG_ACK_WAIT = 2'd2,
    CFG_MAX_TRY  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDBITS = 4'b0010,
    MODE_IDWAIT = 4'b0100,
    MODE_BYTE   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       line_bit;
    logic       busy_res;
  } out_item_t;

  typedef struct packed {
    logic [31:0] id_value;
    logic [15:0] bit_gap_ticks;
    logic [15:0] ack_wait_ticks;
    logic [7:0]  try_limit;
  } cfg_t;

  // Timer reload value: saturates at the counter range, and zero counts as one.
  function automatic logic [TIMER_BITS-1:0] reload(input logic [15:0] ticks);
    logic [32:0] lim;
    logic [32:0] v;
    lim = (33'd1 << TIMER_BITS) - 33'd1;
    v = 33'(ticks);
    if (v > lim) begin
      v = lim;
    end
    if (v == '0) begin
      v = 33'd1;
    end
    return v[TIMER_BITS-1:0];
  endfunction

endpackage

// ===== rtl/absb_cfg.sv =====
// Configuration register file of the bit-serial sender.
module absb_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  output absb_pkg::cfg_t      cfg
);
  import absb_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID_VALUE: cfg_nxt.id_value       = cfg_wdata;
        CFG_BIT_GAP:  cfg_nxt.bit_gap_ticks  = cfg_wdata[15:0];
        CFG_ACK_WAIT: cfg_nxt.ack_wait_ticks = cfg_wdata[15:0];
        CFG_MAX_TRY:  cfg_nxt.try_limit      = cfg_wdata[7:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_value       <= 32'd0;
      cfg_r.bit_gap_ticks  <= 16'd100;
      cfg_r.ack_wait_ticks <= 16'd1000;
      cfg_r.try_limit      <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/absb_core.sv =====
// Sender state and the per-item step logic of the bit-serial sender.
`include "assert_macros.svh"

module absb_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  absb_pkg::in_item_t  item,
  input  absb_pkg::cfg_t      cfg,
  output logic                res_valid,
  output absb_pkg::out_item_t res
);
  import absb_pkg::*;

  mode_t                 mode_r, mode_nxt;
  logic [ID_BITS-1:0]    shift_r, shift_nxt;
  logic [BL_W-1:0]       bits_left_r, bits_left_nxt;
  logic [7:0]            tries_r, tries_nxt;
  logic [TIMER_BITS-1:0] wait_r, wait_nxt;
  logic                  ack_seen_r, ack_seen_nxt;

  logic [TIMER_BITS-1:0] wait_dec;
  logic                  wait_done;
  logic [7:0]            tries_inc;
  logic [BL_W-1:0]       bl_dec;
  logic [BL_W-1:0]       bl_dec2;
  logic [ID_BITS-1:0]    id_ext;

  assign wait_dec  = (wait_r != '0) ? wait_r - TIMER_BITS'(1) : '0;
  assign wait_done = (wait_dec == '0);
  assign tries_inc = tries_r + 8'd1;
  assign bl_dec    = (bits_left_r != '0) ? bits_left_r - BL_W'(1) : '0;
  assign bl_dec2   = (bl_dec != '0) ? bl_dec - BL_W'(1) : '0;
  assign id_ext    = ID_BITS'(cfg.id_value);

  always_comb begin
    mode_nxt      = mode_r;
    shift_nxt     = shift_r;
    bits_left_nxt = bits_left_r;
    tries_nxt     = tries_r;
    wait_nxt      = wait_r;
    ack_seen_nxt  = ack_seen_r;
    res_valid     = 1'b0;
    res           = '0;
    if (step_en) begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (item.command == CMD_START) begin
            tries_nxt     = 8'd0;
            shift_nxt     = id_ext;
            ack_seen_nxt  = 1'b0;
            bits_left_nxt = BL_W'(ID_BITS - 1);
            wait_nxt      = reload(cfg.bit_gap_ticks);
            mode_nxt      = MODE_IDBITS;
            res_valid     = 1'b1;
            res           = '{event_res: EV_BIT, line_bit: id_ext[ID_BITS-1], busy_res: 1'b1};
          end else if (item.command == CMD_BYTE) begin
            tries_nxt     = 8'd0;
            shift_nxt     = ID_BITS'(item.byte_value);
            bits_left_nxt = BYTE_BITS;
            wait_nxt      = reload(cfg.ack_wait_ticks);
            mode_nxt      = MODE_BYTE;
            res_valid     = 1'b1;
            res = '{event_res: EV_BIT, line_bit: item.byte_value[7], busy_res: 1'b1};
          end
        end
        MODE_IDBITS: begin
          if (item.command == CMD_ACK) begin
            ack_seen_nxt = 1'b1;
          end else if (item.command == CMD_TICK) begin
            wait_nxt = wait_dec;
            if (wait_done) begin
              if (bits_left_r != '0) begin
                bits_left_nxt = bl_dec;
                wait_nxt      = reload(cfg.bit_gap_ticks);
                res_valid     = 1'b1;
                res = '{event_res: EV_BIT, line_bit: shift_r[bl_dec[IDX_W-1:0]],
                        busy_res: 1'b1};
              end else if (ack_seen_r) begin
                mode_nxt      = MODE_IDLE;
                bits_left_nxt = '0;
                wait_nxt      = '0;
                ack_seen_nxt  = 1'b0;
                res_valid     = 1'b1;
                res = '{event_res: EV_ID_ACK, line_bit: 1'b0, busy_res: 1'b0};
              end else begin
                mode_nxt = MODE_IDWAIT;
                wait_nxt = reload(cfg.bit_gap_ticks);
              end
            end
          end
        end
        MODE_IDWAIT: begin
          if (item.command == CMD_ACK) begin
            mode_nxt      = MODE_IDLE;
            bits_left_nxt = '0;
            wait_nxt      = '0;
            ack_seen_nxt  = 1'b0;
            res_valid     = 1'b1;
            res = '{event_res: EV_ID_ACK, line_bit: 1'b0, busy_res: 1'b0};
          end else if (item.command == CMD_TICK) begin
            wait_nxt = wait_dec;
            if (wait_done) begin
              tries_nxt = tries_inc;
              res_valid = 1'b1;
              if (tries_inc >= cfg.try_limit) begin
                mode_nxt      = MODE_IDLE;
                bits_left_nxt = '0;
                wait_nxt      = '0;
                ack_seen_nxt  = 1'b0;
                res = '{event_res: EV_ID_TO, line_bit: 1'b0, busy_res: 1'b0};
              end else begin
                shift_nxt     = id_ext;
                ack_seen_nxt  = 1'b0;
                bits_left_nxt = BL_W'(ID_BITS - 1);
                wait_nxt      = reload(cfg.bit_gap_ticks);
                mode_nxt      = MODE_IDBITS;
                res = '{event_res: EV_BIT, line_bit: id_ext[ID_BITS-1], busy_res: 1'b1};
              end
            end
          end
        end
        MODE_BYTE: begin
          if (item.command == CMD_ACK) begin
            tries_nxt     = 8'd0;
            bits_left_nxt = bl_dec;
            res_valid     = 1'b1;
            if (bl_dec == '0) begin
              mode_nxt     = MODE_IDLE;
              wait_nxt     = '0;
              ack_seen_nxt = 1'b0;
              res = '{event_res: EV_BYTE_OK, line_bit: 1'b0, busy_res: 1'b0};
            end else begin
              wait_nxt = reload(cfg.ack_wait_ticks);
              res = '{event_res: EV_BIT, line_bit: shift_r[bl_dec2[IDX_W-1:0]],
                      busy_res: 1'b1};
            end
          end else if (item.command == CMD_TICK) begin
            wait_nxt = wait_dec;
            if (wait_done) begin
              tries_nxt = tries_inc;
              res_valid = 1'b1;
              if (tries_inc >= cfg.try_limit) begin
                mode_nxt      = MODE_IDLE;
                bits_left_nxt = '0;
                wait_nxt      = '0;
                ack_seen_nxt  = 1'b0;
                res = '{event_res: EV_BYTE_TO, line_bit: 1'b0, busy_res: 1'b0};
              end else begin
                wait_nxt = reload(cfg.ack_wait_ticks);
                res = '{event_res: EV_BIT, line_bit: shift_r[bl_dec[IDX_W-1:0]],
                        busy_res: 1'b1};
              end
            end
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      shift_r     <= '0;
      bits_left_r <= '0;
      tries_r     <= 8'd0;
      wait_r      <= '0;
      ack_seen_r  <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      shift_r     <= shift_nxt;
      bits_left_r <= bits_left_nxt;
      tries_r     <= tries_nxt;
      wait_r      <= wait_nxt;
      ack_seen_r  <= ack_seen_nxt;
    end
  end

  `ASSERT_IMPLY(a_idle_clear, mode_r == MODE_IDLE,
    bits_left_r == '0 && wait_r == '0 && ack_seen_r == 1'b0, "idle state not cleared")
  `ASSERT_IMPLY(a_busy_timer, mode_r != MODE_IDLE, wait_r != '0, "busy with an expired timer")
  `ASSERT_IMPLY(a_byte_bits, mode_r == MODE_BYTE,
    bits_left_r != '0 && bits_left_r <= BYTE_BITS, "byte bit count out of range")
  `ASSERT_IMPLY(a_busy_flag, res_valid,
    res.busy_res == (res.event_res == EV_BIT), "busy flag disagrees with event")

endmodule

// ===== rtl/acked_bit_serial_sender_unit.sv =====
// Top level of the acknowledged bit-serial sender.
//
// Input channel (in_valid, in_ready, in_data): one item is a command (tick,
// start identifier frame, send byte, or partner ack) and a byte value.
// Result channel (out_valid, out_ready, out_data): an event code, the line
// bit and a busy flag. An item causes zero or one result item.
// Configuration port (cfg_we, cfg_index, cfg_wdata): to be written only while
// the sender is idle and the result channel is drained; the user must keep to
// this, as the block itself does not enforce it. An accepted item is held in an
// input register and processed once the output register is free; its result,
// if any, is registered in the output register and shown on out_valid. One
// item is taken per cycle as long as the output register is empty or being
// drained in the same cycle. When the receiver stalls, the input register
// fills and in_ready drops after one more item. Reset clears the valid flags
// of both channel registers and the sender state, and loads the configuration
// defaults: identifier 0, bit gap 100 ticks, ack wait 1000 ticks and 10 tries.
module acked_bit_serial_sender_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  absb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output absb_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import absb_pkg::*;

  cfg_t      cfg;
  in_item_t  in_data_r, in_data_nxt;
  logic      in_valid_r, in_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      step_en;
  logic      res_valid;
  out_item_t res;

  absb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  absb_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (in_data_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  assign step_en  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_en;

  always_comb begin
    in_valid_nxt  = (in_valid_r && !step_en) || (in_valid && in_ready);
    in_data_nxt   = (in_valid && in_ready) ? in_data : in_data_r;
    out_valid_nxt = (step_en && res_valid) || (out_valid_r && !out_ready);
    out_data_nxt  = (step_en && res_valid) ? res : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the acknowledged bit-serial sender: directed and random commands.
module testbench;
  import absb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  acked_bit_serial_sender_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  in_item_t  cmd_queue[$];
  out_item_t awaited[$];
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        pushed = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        errors = 0;
  int        cycles = 0;
  int        settings_used = 0;
  int        ev_seen[5] = '{default: 0};

  // Sender state and register copies, as after reset.
  logic [31:0] cf_id = 32'd0;
  logic [15:0] cf_gap = 16'd100;
  logic [15:0] cf_ack_wait = 16'd1000;
  logic [7:0]  cf_tries = 8'd10;
  mode_t       sm_mode = MODE_IDLE;
  logic [31:0] sm_shift = '0;
  logic [5:0]  sm_left = '0;
  logic [7:0]  sm_tries = '0;
  logic [15:0] sm_wait = '0;
  logic        sm_ack = 1'b0;

  function automatic logic [15:0] ticks_of(logic [15:0] r);
    return (r == 16'd0) ? 16'd1 : r;
  endfunction

  function automatic out_item_t make_result(ev_t ev, logic b, logic busy);
    out_item_t r;
    r.event_res = ev;
    r.line_bit = b;
    r.busy_res = busy;
    return r;
  endfunction

  function automatic out_item_t drive_id_bit();
    sm_left = sm_left - 6'd1;
    sm_wait = ticks_of(cf_gap);
    sm_mode = MODE_IDBITS;
    return make_result(EV_BIT, sm_shift[sm_left], 1'b1);
  endfunction

  function automatic out_item_t begin_frame();
    sm_shift = cf_id;
    sm_left = 6'd32;
    sm_ack = 1'b0;
    return drive_id_bit();
  endfunction

  function automatic out_item_t drive_byte_bit();
    sm_wait = ticks_of(cf_ack_wait);
    return make_result(EV_BIT, sm_shift[sm_left - 6'd1], 1'b1);
  endfunction

  function automatic out_item_t back_to_idle(ev_t ev);
    sm_mode = MODE_IDLE;
    sm_left = '0;
    sm_wait = '0;
    sm_ack = 1'b0;
    return make_result(ev, 1'b0, 1'b0);
  endfunction

  function automatic bit wait_ran_out();
    if (sm_wait != 16'd0) begin
      sm_wait = sm_wait - 16'd1;
    end
    return sm_wait == 16'd0;
  endfunction

  // Advances the sender by one command and returns whether it emits an event.
  function automatic bit sender_step(input in_item_t it, output out_item_t res);
    cmd_t cmd;
    cmd = cmd_t'(it.command);
    res = '0;
    case (sm_mode)
      MODE_IDLE: begin
        if (cmd == CMD_START) begin
          sm_tries = '0;
          res = begin_frame();
          return 1'b1;
        end
        if (cmd == CMD_BYTE) begin
          sm_shift = {24'd0, it.byte_value};
          sm_left = 6'd8;
          sm_tries = '0;
          sm_mode = MODE_BYTE;
          res = drive_byte_bit();
          return 1'b1;
        end
        return 1'b0;
      end
      MODE_IDBITS: begin
        if (cmd == CMD_ACK) begin
          sm_ack = 1'b1;
          return 1'b0;
        end
        if (cmd != CMD_TICK) return 1'b0;
        if (!wait_ran_out()) return 1'b0;
        if (sm_left != 6'd0) begin
          res = drive_id_bit();
          return 1'b1;
        end
        if (sm_ack) begin
          res = back_to_idle(EV_ID_ACK);
          return 1'b1;
        end
        sm_mode = MODE_IDWAIT;
        sm_wait = ticks_of(cf_gap);
        return 1'b0;
      end
      MODE_IDWAIT: begin
        if (cmd == CMD_ACK) begin
          res = back_to_idle(EV_ID_ACK);
          return 1'b1;
        end
        if (cmd != CMD_TICK) return 1'b0;
        if (!wait_ran_out()) return 1'b0;
        sm_tries = sm_tries + 8'd1;
        if (sm_tries >= cf_tries) res = back_to_idle(EV_ID_TO);
        else res = begin_frame();
        return 1'b1;
      end
      default: begin
        if (cmd == CMD_ACK) begin
          sm_tries = '0;
          if (sm_left != 6'd0) sm_left = sm_left - 6'd1;
          if (sm_left == 6'd0) res = back_to_idle(EV_BYTE_OK);
          else res = drive_byte_bit();
          return 1'b1;
        end
        if (cmd != CMD_TICK) return 1'b0;
        if (!wait_ran_out()) return 1'b0;
        sm_tries = sm_tries + 8'd1;
        if (sm_tries >= cf_tries) res = back_to_idle(EV_BYTE_TO);
        else res = drive_byte_bit();
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void push_cmd(cmd_t c, logic [7:0] b);
    in_item_t it;
    it.command = c;
    it.byte_value = b;
    cmd_queue.push_back(it);
    pushed++;
  endfunction

  function automatic void push_ticks(int n);
    repeat (n) push_cmd(CMD_TICK, 8'($urandom_range(0, 255)));
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("acked_bit_serial_sender_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        items_sent++;
        if (sender_step(in_data, res)) begin
          awaited.push_back(res);
        end
      end
      if (!in_valid || in_ready) begin
        if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= cmd_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.event_res <= 3'd4) ev_seen[out_data.event_res]++;
      if (awaited.size() == 0) begin
        $error("unexpected result: event_res %0d line_bit %0d busy_res %0d",
               out_data.event_res, out_data.line_bit, out_data.busy_res);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (out_data.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, out_data.event_res);
          errors++;
        end
        if (out_data.line_bit !== want.line_bit) begin
          $error("line_bit: expected %0d, got %0d", want.line_bit, out_data.line_bit);
          errors++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Waits until every item is taken and every event is back, then closes any
  // open frame or byte with acks and ticks so that the sender ends up idle.
  task automatic settle();
    int n;
    while (1) begin
      do @(negedge clk); while (cmd_queue.size() != 0 || in_valid || awaited.size() != 0);
      if (sm_mode == MODE_IDLE) break;
      push_cmd(CMD_ACK, 8'($urandom_range(0, 255)));
      if (sm_mode == MODE_IDBITS) begin
        n = sm_wait + sm_left * ticks_of(cf_gap);
        push_ticks(n);
      end
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_settings(logic [31:0] id, logic [15:0] gap, logic [15:0] wt,
                               logic [7:0] tries);
    write_reg(CFG_ID_VALUE, id);
    write_reg(CFG_BIT_GAP, {16'd0, gap});
    write_reg(CFG_ACK_WAIT, {16'd0, wt});
    write_reg(CFG_MAX_TRY, {24'd0, tries});
    @(posedge clk);
    cfg_we <= 1'b0;
    cf_id = id;
    cf_gap = gap;
    cf_ack_wait = wt;
    cf_tries = tries;
    settings_used++;
  endtask

  // Mostly complete identifier frames and bytes, with a partner that answers
  // early, late or never, and some stray commands in between.
  task automatic gen_random(int target, bit with_id, bit id_acked, bit byte_acked);
    int start_count;
    int g;
    int w;
    int m;
    int b;
    int misses;
    int frames;
    int outcome;
    int pos;
    cmd_t c;
    start_count = pushed;
    g = ticks_of(cf_gap);
    w = ticks_of(cf_ack_wait);
    m = (cf_tries == 8'd0) ? 1 : cf_tries;
    while (pushed - start_count < target) begin
      if ($urandom_range(0, 9) == 0) begin
        c = cmd_t'($urandom_range(0, 3));
        if (!with_id && c == CMD_START) c = CMD_TICK;
        push_cmd(c, 8'($urandom_range(0, 255)));
      end else if (with_id && $urandom_range(0, 2) == 0) begin
        push_cmd(CMD_START, 8'($urandom_range(0, 255)));
        frames = 0;
        while (1) begin
          outcome = id_acked ? $urandom_range(0, 1) : $urandom_range(0, 2);
          pos = $urandom_range(0, 32 * g - 1);
          for (int k = 0; k < 32 * g; k++) begin
            push_ticks(1);
            if (outcome == 0 && k == pos) push_cmd(CMD_ACK, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 49) == 0) begin
              push_cmd(cmd_t'($urandom_range(1, 2)), 8'($urandom_range(0, 255)));
            end
          end
          if (outcome == 0) break;
          if (outcome == 1) begin
            push_ticks($urandom_range(0, g - 1));
            push_cmd(CMD_ACK, 8'($urandom_range(0, 255)));
            break;
          end
          push_ticks(g);
          frames++;
          if (frames >= m) break;
        end
      end else begin
        push_cmd(CMD_BYTE, 8'($urandom_range(0, 255)));
        if (!byte_acked && $urandom_range(0, 5) == 0) begin
          push_ticks(m * w);
        end else begin
          b = 0;
          misses = 0;
          while (b < 8) begin
            if (!byte_acked && $urandom_range(0, 4) == 0) begin
              push_ticks(w);
              misses++;
              if (misses >= m) break;
            end else begin
              push_ticks($urandom_range(0, (w > 4) ? 4 : w - 1));
              push_cmd(CMD_ACK, 8'($urandom_range(0, 255)));
              misses = 0;
              b++;
            end
          end
        end
      end
    end
  endtask

  task automatic run_settings(logic [31:0] id, logic [15:0] gap, logic [15:0] wt,
                              logic [7:0] tries, int target, bit with_id, bit id_acked,
                              bit byte_acked, int sidle, int ridle);
    load_settings(id, gap, wt, tries);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    @(negedge clk);
    gen_random(target, with_id, id_acked, byte_acked);
    settle();
  endtask

  initial begin
    send_idle_pct = 10;
    recv_idle_pct = 45;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Zero timer registers count as one tick, and zero tries time out at once.
    load_settings(32'hA5A5_F00F, 16'd0, 16'd0, 8'd0);
    @(negedge clk);
    push_cmd(CMD_ACK, 8'hFF);
    push_cmd(CMD_TICK, 8'h00);
    push_cmd(CMD_BYTE, 8'hFF);
    push_cmd(CMD_BYTE, 8'h00);
    push_cmd(CMD_START, 8'hFF);
    push_cmd(CMD_ACK, 8'h00);
    push_cmd(CMD_TICK, 8'hFF);
    push_cmd(CMD_BYTE, 8'h00);
    repeat (8) push_cmd(CMD_ACK, 8'h55);
    push_cmd(CMD_START, 8'hAA);
    push_cmd(CMD_ACK, 8'h00);
    push_cmd(CMD_BYTE, 8'hFF);
    push_cmd(CMD_START, 8'h00);
    push_ticks(32);
    settle();

    run_settings(32'hA5A5_F00F, 16'd0, 16'd0, 8'd0, 150, 1'b1, 1'b0, 1'b0, 10, 45);
    run_settings(32'd0, 16'd1, 16'd2, 8'd3, 200, 1'b1, 1'b0, 1'b0, 10, 45);
    run_settings(32'hFFFF_FFFF, 16'd2, 16'd1, 8'd255, 200, 1'b1, 1'b1, 1'b0, 45, 10);
    run_settings($urandom, 16'd65535, 16'd65535, 8'd1, 100, 1'b0, 1'b1, 1'b1, 45, 10);
    run_settings($urandom, 16'd3, 16'd3, 8'd2, 200, 1'b1, 1'b0, 1'b0, 0, 0);
    run_settings($urandom, 16'd1, 16'd1, 8'd1, 150, 1'b1, 1'b0, 1'b0, 0, 0);

    repeat (10) @(posedge clk);
    $display("Sent %0d commands under %0d register settings and checked %0d events.",
             items_sent, settings_used, results_seen);
    $display("Events: %0d bits, %0d id acks, %0d bytes, %0d id timeouts, %0d byte timeouts.",
             ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3], ev_seen[4]);
    if (errors == 0 && awaited.size() == 0) begin
      $display("acked_bit_serial_sender_unit: match");
    end else begin
      $display("acked_bit_serial_sender_unit: mismatch");
    end
    $finish;
  end

endmodule
